/* hw/rtl/pft_pkg.sv */
// ----------------------------------------------------------------------------
// pft_pkg
// Types and constants shared by the protobuf field tokenizer modules.
// ----------------------------------------------------------------------------
package pft_pkg;

    localparam int QUEUE_DEPTH = 4;

    localparam logic [3:0] VARINT_LAST_STEP = 4'd9;
    localparam logic [63:0] SKIP_I64 = 64'd8;
    localparam logic [63:0] SKIP_I32 = 64'd4;

    localparam logic [2:0] WT_VARINT = 3'd0;
    localparam logic [2:0] WT_I64    = 3'd1;
    localparam logic [2:0] WT_LEN    = 3'd2;
    localparam logic [2:0] WT_I32    = 3'd5;

    localparam logic [1:0] ERR_NONE      = 2'd0;
    localparam logic [1:0] ERR_MALFORMED = 2'd1;
    localparam logic [1:0] ERR_WIRE_TYPE = 2'd2;

    typedef enum logic [1:0] {
        PH_KEY,
        PH_VALUE,
        PH_LENGTH,
        PH_SKIP
    } t_phase;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       last_byte;
    } t_in_beat;

    typedef struct packed {
        logic [31:0] field_number;
        logic [2:0]  wire_type;
        logic [63:0] field_value;
        logic [1:0]  error_code;
        logic        ends_message;
    } t_out_beat;

    // classified byte handed from front to back
    typedef struct packed {
        logic [6:0] payload;
        logic       cont;
        logic       above_one;
        logic       last;
    } t_token;

endpackage

/* hw/rtl/protobuf_field_tokenizer.sv */
// ----------------------------------------------------------------------------
// protobuf_field_tokenizer
// Splits a protobuf wire-format byte stream into field results.
// ----------------------------------------------------------------------------
// Sustains one byte per cycle. Each accepted byte enters a QUEUE_DEPTH-entry
// token queue; the parser takes one token per cycle and any result sits in an
// output register, so a result reaches the output through the queue and then
// the output register. A stalled output holds the parser only on bytes that make a
// result; the queue keeps absorbing input until it fills, then o_in_stall
// rises. At most one result per byte; bytes after an error give no result up
// to the message's last byte.
module protobuf_field_tokenizer #(
    parameter int QUEUE_DEPTH = pft_pkg::QUEUE_DEPTH
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_stall,
    input  pft_pkg::t_in_beat  i_in_beat,
    output logic               o_out_valid,
    input  logic               i_out_stall,
    output pft_pkg::t_out_beat o_out_beat
);

    logic            w_head_valid;
    pft_pkg::t_token w_head;
    logic            w_pop;

    pft_front #(
        .QUEUE_DEPTH(QUEUE_DEPTH)
    ) u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_beat   (i_in_beat),
        .o_head_valid(w_head_valid),
        .o_head      (w_head),
        .i_pop       (w_pop)
    );

    pft_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_head_valid(w_head_valid),
        .i_head      (w_head),
        .o_pop       (w_pop),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_beat  (o_out_beat)
    );

endmodule

/* hw/rtl/pft_front.sv */
// ----------------------------------------------------------------------------
// pft_front
// Accepts message bytes, splits each into varint payload and flags, and
// queues the tokens for the parser.
// ----------------------------------------------------------------------------
module pft_front #(
    parameter int QUEUE_DEPTH = pft_pkg::QUEUE_DEPTH
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_stall,
    input  pft_pkg::t_in_beat i_in_beat,
    output logic              o_head_valid,
    output pft_pkg::t_token   o_head,
    input  logic              i_pop
);

    localparam int PTR_W = $clog2(QUEUE_DEPTH);
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(QUEUE_DEPTH - 1);
    localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(QUEUE_DEPTH);

    pft_pkg::t_token r_mem [QUEUE_DEPTH];
    logic [PTR_W-1:0] r_wr_ptr, n_wr_ptr;
    logic [PTR_W-1:0] r_rd_ptr, n_rd_ptr;
    logic [CNT_W-1:0] r_count, n_count;
    pft_pkg::t_token  w_token;
    logic             w_push;
    logic             w_pop;
    logic             w_full;

    assign w_full       = (r_count == CNT_FULL);
    assign o_in_stall   = w_full;
    assign o_head_valid = (r_count != '0);
    assign o_head       = r_mem[r_rd_ptr];
    assign w_push       = i_in_valid && !w_full;
    assign w_pop        = i_pop && o_head_valid;

    always_comb begin
        w_token.payload   = i_in_beat.data_byte[6:0];
        w_token.cont      = i_in_beat.data_byte[7];
        w_token.above_one = (i_in_beat.data_byte[7:1] != 7'd0);
        w_token.last      = i_in_beat.last_byte;
    end

    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (w_push) begin
            n_wr_ptr = (r_wr_ptr == PTR_LAST) ? '0 : r_wr_ptr + 1'b1;
        end
        if (w_pop) begin
            n_rd_ptr = (r_rd_ptr == PTR_LAST) ? '0 : r_rd_ptr + 1'b1;
        end
        if (w_push && !w_pop) begin
            n_count = r_count + 1'b1;
        end else if (!w_push && w_pop) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_mem[r_wr_ptr] <= w_token;
        end
    end

`ifndef SYNTHESIS
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_FULL)
        else $error("queue count beyond depth");

    a_count_track: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_push && !w_pop) |=> r_count == $past(r_count) + 1'b1)
        else $error("queue count missed a push");
`endif

endmodule

/* hw/rtl/pft_back.sv */
// ----------------------------------------------------------------------------
// pft_back
// Wire-format parser: takes queued byte tokens, decodes key, varint, length
// and skip phases, and registers one result beat per completed field or fault.
// ----------------------------------------------------------------------------
module pft_back (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_head_valid,
    input  pft_pkg::t_token    i_head,
    output logic               o_pop,
    output logic               o_out_valid,
    input  logic               i_out_stall,
    output pft_pkg::t_out_beat o_out_beat
);

    pft_pkg::t_phase    r_phase, n_phase;
    logic [63:0]        r_acc, n_acc;
    logic [3:0]         r_step, n_step;
    logic [63:0]        r_skip, n_skip;
    logic [31:0]        r_held_num, n_held_num;
    logic [2:0]         r_held_wire, n_held_wire;
    logic               r_discard, n_discard;
    logic               r_out_valid;
    pft_pkg::t_out_beat r_out;

    logic [63:0]        w_merged;
    logic               w_vbad;
    logic               w_vdone;
    logic [2:0]         w_key_wire;
    logic [63:0]        w_skip_dec;
    logic               w_emit;
    logic               w_fail;
    logic               w_fin;
    pft_pkg::t_out_beat w_res;
    logic               w_slot_free;
    logic               w_fire;

    assign w_merged = r_acc | ({57'd0, i_head.payload} << (7'(r_step) * 7'd7));
    assign w_vbad   = (r_step > pft_pkg::VARINT_LAST_STEP) ||
                      ((r_step == pft_pkg::VARINT_LAST_STEP) && i_head.above_one);
    assign w_vdone    = !i_head.cont;
    assign w_key_wire = w_merged[2:0];
    assign w_skip_dec = (r_skip == 64'd0) ? 64'd0 : r_skip - 64'd1;

    // step outcome: result beat and whether it closes the field
    always_comb begin
        w_fail             = 1'b0;
        w_fin              = 1'b0;
        w_res.field_number = r_held_num;
        w_res.wire_type    = r_held_wire;
        w_res.field_value  = 64'd0;
        w_res.error_code   = pft_pkg::ERR_MALFORMED;
        w_res.ends_message = i_head.last;
        unique case (r_phase)
            pft_pkg::PH_KEY: begin
                w_res.field_number = 32'd0;
                w_res.wire_type    = 3'd0;
                if (w_vbad || (!w_vdone && i_head.last) || (w_vdone && w_merged == 64'd0)) begin
                    w_fail = 1'b1;
                end else if (w_vdone) begin
                    if (w_key_wire != pft_pkg::WT_VARINT && w_key_wire != pft_pkg::WT_I64 &&
                        w_key_wire != pft_pkg::WT_LEN && w_key_wire != pft_pkg::WT_I32) begin
                        w_fail             = 1'b1;
                        w_res.error_code   = pft_pkg::ERR_WIRE_TYPE;
                        w_res.field_number = w_merged[34:3];
                        w_res.wire_type    = w_key_wire;
                    end else if (i_head.last) begin
                        w_fail             = 1'b1;
                        w_res.field_number = w_merged[34:3];
                        w_res.wire_type    = w_key_wire;
                    end
                end
            end
            pft_pkg::PH_VALUE: begin
                if (w_vbad || (!w_vdone && i_head.last)) begin
                    w_fail = 1'b1;
                end else if (w_vdone) begin
                    w_fin             = 1'b1;
                    w_res.field_value = w_merged;
                    w_res.error_code  = pft_pkg::ERR_NONE;
                end
            end
            pft_pkg::PH_LENGTH: begin
                if (w_vbad || (!w_vdone && i_head.last)) begin
                    w_fail = 1'b1;
                end else if (w_vdone && w_merged == 64'd0) begin
                    w_fin            = 1'b1;
                    w_res.error_code = pft_pkg::ERR_NONE;
                end else if (w_vdone && i_head.last) begin
                    w_fail = 1'b1;
                end
            end
            pft_pkg::PH_SKIP: begin
                if (w_skip_dec == 64'd0) begin
                    w_fin             = 1'b1;
                    w_res.field_value = r_acc;
                    w_res.error_code  = pft_pkg::ERR_NONE;
                end else if (i_head.last) begin
                    w_fail = 1'b1;
                end
            end
            default: begin
                w_fail = 1'b1;
            end
        endcase
        if (w_fail) begin
            w_res.field_value = 64'd0;
        end
        w_emit = !r_discard && (w_fail || w_fin);
    end

    assign w_slot_free = !r_out_valid || !i_out_stall;
    assign w_fire      = i_head_valid && (!w_emit || w_slot_free);
    assign o_pop       = w_fire;

    // next state
    always_comb begin
        n_phase     = r_phase;
        n_acc       = r_acc;
        n_step      = r_step;
        n_skip      = r_skip;
        n_held_num  = r_held_num;
        n_held_wire = r_held_wire;
        n_discard   = r_discard;
        if (w_fire) begin
            if (r_discard) begin
                if (i_head.last) begin
                    n_discard = 1'b0;
                    n_phase   = pft_pkg::PH_KEY;
                    n_acc     = 64'd0;
                    n_step    = 4'd0;
                    n_skip    = 64'd0;
                end
            end else if (w_fail || w_fin) begin
                n_phase     = pft_pkg::PH_KEY;
                n_acc       = 64'd0;
                n_step      = 4'd0;
                n_skip      = 64'd0;
                n_held_num  = 32'd0;
                n_held_wire = 3'd0;
                if (w_fail) begin
                    n_discard = !i_head.last;
                end
            end else begin
                unique case (r_phase)
                    pft_pkg::PH_KEY: begin
                        if (w_vdone) begin
                            n_held_num  = w_merged[34:3];
                            n_held_wire = w_key_wire;
                            n_acc       = 64'd0;
                            n_step      = 4'd0;
                            if (w_key_wire == pft_pkg::WT_VARINT) begin
                                n_phase = pft_pkg::PH_VALUE;
                            end else if (w_key_wire == pft_pkg::WT_LEN) begin
                                n_phase = pft_pkg::PH_LENGTH;
                            end else if (w_key_wire == pft_pkg::WT_I64) begin
                                n_phase = pft_pkg::PH_SKIP;
                                n_skip  = pft_pkg::SKIP_I64;
                            end else begin
                                n_phase = pft_pkg::PH_SKIP;
                                n_skip  = pft_pkg::SKIP_I32;
                            end
                        end else begin
                            n_acc  = w_merged;
                            n_step = r_step + 4'd1;
                        end
                    end
                    pft_pkg::PH_VALUE: begin
                        n_acc  = w_merged;
                        n_step = r_step + 4'd1;
                    end
                    pft_pkg::PH_LENGTH: begin
                        n_acc = w_merged;
                        if (w_vdone) begin
                            n_skip  = w_merged;
                            n_step  = 4'd0;
                            n_phase = pft_pkg::PH_SKIP;
                        end else begin
                            n_step = r_step + 4'd1;
                        end
                    end
                    pft_pkg::PH_SKIP: begin
                        n_skip = w_skip_dec;
                    end
                    default: begin
                        n_phase = pft_pkg::PH_KEY;
                    end
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase     <= pft_pkg::PH_KEY;
            r_acc       <= 64'd0;
            r_step      <= 4'd0;
            r_skip      <= 64'd0;
            r_held_num  <= 32'd0;
            r_held_wire <= 3'd0;
            r_discard   <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_phase     <= n_phase;
            r_acc       <= n_acc;
            r_step      <= n_step;
            r_skip      <= n_skip;
            r_held_num  <= n_held_num;
            r_held_wire <= n_held_wire;
            r_discard   <= n_discard;
            if (w_slot_free) begin
                r_out_valid <= w_fire && w_emit;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_slot_free && w_fire && w_emit) begin
            r_out <= w_res;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_beat  = r_out;

`ifndef SYNTHESIS
    a_step_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_step <= pft_pkg::VARINT_LAST_STEP)
        else $error("varint step past tenth byte");

    a_discard_key: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_discard |-> r_phase == pft_pkg::PH_KEY)
        else $error("discarding outside key phase");

    a_err_value: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_out_beat.error_code != pft_pkg::ERR_NONE)
            |-> o_out_beat.field_value == 64'd0)
        else $error("error beat carries a value");

    a_no_emit_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_emit && i_head_valid && !w_slot_free) |-> !o_pop)
        else $error("token popped with result slot busy");
`endif

endmodule
